@@ rtl/mipds_pkg.sv @@
// mipds_pkg: shared types, constants and channel arithmetic for the 2x2 mip downsampler
// used by mipds_position, mipds_filter and mip_downsample_box2x2; no dependencies
package mipds_pkg;

   localparam int PIX_W     = 32;
   localparam int BYTE_W    = 8;
   localparam int CH_NUM    = 4;
   localparam int CH_W      = 9;
   localparam int SUM_W     = CH_NUM * CH_W;
   localparam int CFG_W_W   = 12;
   localparam int CFG_H_W   = 16;
   localparam int CSR_IDX_W = 1;
   localparam int CSR_DAT_W = 16;
   localparam int ALPHA_CH  = 3;

   localparam logic [CSR_IDX_W-1:0] REG_IMAGE_WIDTH  = 1'd0;
   localparam logic [CSR_IDX_W-1:0] REG_IMAGE_HEIGHT = 1'd1;

   localparam logic [CFG_W_W-1:0] WIDTH_RESET  = 12'd2;
   localparam logic [CFG_H_W-1:0] HEIGHT_RESET = 16'd2;
   localparam logic [BYTE_W-1:0]  ALPHA_MAX    = 8'd255;

   // position of the current beat within the 2x2 block and the image
   typedef struct packed {
      logic col_odd;
      logic row_odd;
      logic last;
   } pos_flags_type;

   // per-channel sums of two pixels, four 9-bit fields, channel 0 lowest
   function automatic logic [SUM_W-1:0] pair_sums(input logic [PIX_W-1:0] a,
                                                  input logic [PIX_W-1:0] b);
      logic [SUM_W-1:0] sums;
      sums = '0;
      for (int ch = 0; ch < CH_NUM; ch++) begin
         sums[ch*CH_W +: CH_W] = {1'b0, a[ch*BYTE_W +: BYTE_W]}
                               + {1'b0, b[ch*BYTE_W +: BYTE_W]};
      end
      return sums;
   endfunction

   // four-pixel average; alpha gets an eighth added and saturates
   function automatic logic [PIX_W-1:0] filter_pixel(input logic [SUM_W-1:0] cur,
                                                     input logic [SUM_W-1:0] above);
      logic [PIX_W-1:0] pix;
      logic [CH_W:0]    s;
      logic [CH_W+1:0]  boosted;
      logic [CH_W-1:0]  quarter;
      pix = '0;
      for (int ch = 0; ch < ALPHA_CH; ch++) begin
         s = {1'b0, cur[ch*CH_W +: CH_W]} + {1'b0, above[ch*CH_W +: CH_W]};
         pix[ch*BYTE_W +: BYTE_W] = s[CH_W:2];
      end
      s = {1'b0, cur[ALPHA_CH*CH_W +: CH_W]} + {1'b0, above[ALPHA_CH*CH_W +: CH_W]};
      boosted = {1'b0, s} + {4'd0, s[CH_W:3]};
      quarter = boosted[CH_W+1:2];
      pix[ALPHA_CH*BYTE_W +: BYTE_W] = quarter[CH_W-1] ? ALPHA_MAX : quarter[BYTE_W-1:0];
      return pix;
   endfunction

endpackage

@@ rtl/mipds_line_store.sv @@
// mipds_line_store: single-port line store for the pair sums of one even row
// registered read data; no package dependencies
module mipds_line_store #(
   parameter int DEPTH  = 1024,
   parameter int ADDR_W = 10,
   parameter int DATA_W = 36
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] addr,
   input  logic [DATA_W-1:0] wr_data,
   output logic [DATA_W-1:0] rd_data
);

   logic [DATA_W-1:0] mem [DEPTH];
   logic [DATA_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ rtl/mipds_position.sv @@
// mipds_position: column and row counters with effective image size and last-output flag
// depends on mipds_pkg
module mipds_position #(
   parameter  int MAX_WIDTH = 2048,
   localparam int SlotW     = (MAX_WIDTH / 2 > 1) ? $clog2(MAX_WIDTH / 2) : 1
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic [mipds_pkg::CFG_W_W-1:0]     image_width,
   input  logic [mipds_pkg::CFG_H_W-1:0]     image_height,
   input  logic                              frame_start,
   input  logic                              advance,
   output logic [SlotW-1:0]                  slot,
   output mipds_pkg::pos_flags_type          flags
);

   localparam int ColW    = $clog2(MAX_WIDTH);
   localparam int EffW    = (ColW + 1 > mipds_pkg::CFG_W_W) ? ColW + 1 : mipds_pkg::CFG_W_W;
   localparam int MaxEven = (MAX_WIDTH / 2) * 2;
   localparam int HW      = mipds_pkg::CFG_H_W;

   logic [ColW-1:0] col_ff, col_in, col;
   logic [HW-1:0]   row_ff, row_in, row;
   logic [EffW-1:0] width_masked, eff_w, col_sum;
   logic [HW-1:0]   eff_h;
   logic [HW:0]     row_sum;
   logic            col_wrap, row_wrap;

   // effective size: even, at least two, width clamped to the store
   always_comb begin
      width_masked = EffW'({image_width[mipds_pkg::CFG_W_W-1:1], 1'b0});
      if (width_masked < EffW'(2)) begin
         eff_w = EffW'(2);
      end else if (width_masked > EffW'(MAX_WIDTH)) begin
         eff_w = EffW'(MaxEven);
      end else begin
         eff_w = width_masked;
      end
      eff_h = {image_height[HW-1:1], 1'b0};
      if (eff_h == '0) begin
         eff_h = HW'(2);
      end
   end

   always_comb begin
      col      = frame_start ? '0 : col_ff;
      row      = frame_start ? '0 : row_ff;
      col_sum  = EffW'(col) + EffW'(1);
      row_sum  = {1'b0, row} + (HW+1)'(1);
      col_wrap = col_sum >= eff_w;
      row_wrap = row_sum >= {1'b0, eff_h};
      col_in   = col_wrap ? '0 : col_sum[ColW-1:0];
      if (col_wrap) begin
         row_in = row_wrap ? '0 : row_sum[HW-1:0];
      end else begin
         row_in = row;
      end
   end

   assign slot          = SlotW'(col >> 1);
   assign flags.col_odd = col[0];
   assign flags.row_odd = row[0];
   assign flags.last    = (EffW'(col) == eff_w - EffW'(1)) && (row == eff_h - HW'(1));

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
      end else if (advance) begin
         col_ff <= col_in;
         row_ff <= row_in;
      end
   end

endmodule

@@ rtl/mipds_filter.sv @@
// mipds_filter: final channel adds and alpha boost into the result register
// depends on mipds_pkg
module mipds_filter (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            load,
   input  logic [mipds_pkg::SUM_W-1:0]     cur_sums,
   input  logic [mipds_pkg::SUM_W-1:0]     above_sums,
   input  logic                            last,
   output logic                            free,
   input  logic                            rsp_tready,
   output logic                            rsp_tvalid,
   output logic [mipds_pkg::PIX_W-1:0]     rsp_tdata,   // mip_pixel [31:0]
   output logic                            rsp_tlast
);

   logic                        valid_ff, valid_in;
   logic [mipds_pkg::PIX_W-1:0] pix_ff;
   logic                        last_ff;

   // result register frees when empty or its beat is taken
   assign free = !valid_ff || rsp_tready;

   always_comb begin
      valid_in = valid_ff;
      if (load) begin
         valid_in = 1'b1;
      end else if (rsp_tready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         pix_ff  <= mipds_pkg::filter_pixel(cur_sums, above_sums);
         last_ff <= last;
      end
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = pix_ff;
   assign rsp_tlast  = last_ff;

endmodule

@@ rtl/mip_downsample_box2x2.sv @@
// mip_downsample_box2x2: top level of the 2x2 box-filter mipmap downsampler
// depends on mipds_pkg, mipds_position, mipds_line_store and mipds_filter
//
// usage
//  - req channel: one source pixel per beat in raster order, tdata is the pixel
//    (byte 0 lowest, byte 3 alpha), tuser flags the first pixel of an image
//  - rsp channel: one filtered pixel per 2x2 block, sent on the second pixel of
//    each pair in an odd row; tlast marks the bottom-right block of the image
//  - csr channel: index 0 is image width, index 1 is image height, both even;
//    write only while the block is idle, csr_ready is always high
//  - one pixel is accepted every cycle unless the rsp side stalls; the beat that
//    completes a block reaches the rsp channel through the input register, the
//    line-store read register and the result register
//  - the line store keeps one pair sum per two columns of the previous even row,
//    one port, written on even rows and read on odd rows
//  - reset clears the position to the top-left corner, the size to 2x2 and all
//    valid flags; the line store is not cleared and needs no clearing pass
//  - a stalled rsp side blocks req once the result register and the block
//    waiting behind it are both full; the beat in the input register then
//    waits whether or not it makes a result
module mip_downsample_box2x2 #(
   parameter int MAX_WIDTH = 2048
) (
   input  logic                              clock,
   input  logic                              reset,
   // source pixels
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [mipds_pkg::PIX_W-1:0]       req_tdata,   // pixel_word [31:0]
   input  logic                              req_tuser,   // frame_start [0]
   // filtered pixels
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [mipds_pkg::PIX_W-1:0]       rsp_tdata,   // mip_pixel [31:0]
   output logic                              rsp_tlast,
   // register writes
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [mipds_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [mipds_pkg::CSR_DAT_W-1:0]   csr_data
);

   localparam int StoreDepth = MAX_WIDTH / 2;
   localparam int SlotW      = (StoreDepth > 1) ? $clog2(StoreDepth) : 1;

   // configuration registers
   logic [mipds_pkg::CFG_W_W-1:0] width_ff;
   logic [mipds_pkg::CFG_H_W-1:0] height_ff;

   // input register
   logic                        in_valid_ff, in_valid_in;
   logic [mipds_pkg::PIX_W-1:0] pix_ff;
   logic                        fs_ff;

   // first pixel of the current pair
   logic [mipds_pkg::PIX_W-1:0] held_ff;

   // block waiting for the line-store read
   logic                        s1_valid_ff, s1_valid_in;
   logic [mipds_pkg::SUM_W-1:0] cur_ff;
   logic                        last_ff;

   logic                        in_adv, emit, s1_move, out_free;
   logic                        wr_en, rd_en;
   logic [SlotW-1:0]            slot;
   logic [mipds_pkg::SUM_W-1:0] cur_sums, above_sums;
   mipds_pkg::pos_flags_type    flags;

   // config writes
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= mipds_pkg::WIDTH_RESET;
         height_ff <= mipds_pkg::HEIGHT_RESET;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            mipds_pkg::REG_IMAGE_WIDTH: begin
               width_ff <= csr_data[mipds_pkg::CFG_W_W-1:0];
            end
            mipds_pkg::REG_IMAGE_HEIGHT: begin
               height_ff <= csr_data;
            end
            default: begin
            end
         endcase
      end
   end

   // pipeline control: only a result-bearing block can hold up the input
   assign s1_move    = s1_valid_ff && out_free;
   assign in_adv     = in_valid_ff && (!s1_valid_ff || out_free);
   assign req_tready = !in_valid_ff || in_adv;
   assign emit       = in_adv && flags.col_odd && flags.row_odd;
   assign wr_en      = in_adv && flags.col_odd && !flags.row_odd;
   assign rd_en      = emit;
   assign cur_sums   = mipds_pkg::pair_sums(held_ff, pix_ff);

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_tvalid && req_tready) begin
         in_valid_in = 1'b1;
      end else if (in_adv) begin
         in_valid_in = 1'b0;
      end
      s1_valid_in = s1_valid_ff;
      if (emit) begin
         s1_valid_in = 1'b1;
      end else if (s1_move) begin
         s1_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
         s1_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         pix_ff <= req_tdata;
         fs_ff  <= req_tuser;
      end
      if (emit) begin
         cur_ff  <= cur_sums;
         last_ff <= flags.last;
      end
   end

   // held pixel resets to zero like the rest of the position state
   always_ff @(posedge clock) begin
      if (reset) begin
         held_ff <= '0;
      end else if (in_adv && !flags.col_odd) begin
         held_ff <= pix_ff;
      end
   end

   mipds_position #(
      .MAX_WIDTH (MAX_WIDTH)
   ) u_position (
      .clock        (clock),
      .reset        (reset),
      .image_width  (width_ff),
      .image_height (height_ff),
      .frame_start  (fs_ff),
      .advance      (in_adv),
      .slot         (slot),
      .flags        (flags)
   );

   mipds_line_store #(
      .DEPTH  (StoreDepth),
      .ADDR_W (SlotW),
      .DATA_W (mipds_pkg::SUM_W)
   ) u_line_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .rd_en   (rd_en),
      .addr    (slot),
      .wr_data (cur_sums),
      .rd_data (above_sums)
   );

   mipds_filter u_filter (
      .clock      (clock),
      .reset      (reset),
      .load       (s1_move),
      .cur_sums   (cur_ff),
      .above_sums (above_sums),
      .last       (last_ff),
      .free       (out_free),
      .rsp_tready (rsp_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   // a block leaving the input register never lands on an unsent block
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      emit |-> (!s1_valid_ff || s1_move))
      else $error("waiting block overwritten");

   // input only stalls when both the result and the block behind it are full
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> (in_valid_ff && s1_valid_ff && rsp_tvalid))
      else $error("input stalled without a full pipeline");

   // a new result beat always comes from a waiting block
   a_result_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(s1_valid_ff))
      else $error("result beat without a source block");

   // line store is never written and read by the same beat
   a_store_port: assert property (@(posedge clock) disable iff (reset)
      !(wr_en && rd_en))
      else $error("line store port conflict");

endmodule
